// File: design/ptq_pkg.sv
// Shared types and constants for the pointer tracker event queue.
// Depends on nothing; imported by the controller, datapath and top level.
`default_nettype none

package ptq_pkg;

    // Input operation codes
    localparam logic OP_MOTION = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_MAP   = 3'd0,
        CFG_SCROLL_SWAP  = 3'd1,
        CFG_ACCELERATION = 3'd2,
        CFG_CLIP_MIN_X   = 3'd3,
        CFG_CLIP_MIN_Y   = 3'd4,
        CFG_CLIP_MAX_X   = 3'd5,
        CFG_CLIP_MAX_Y   = 3'd6
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [23:0]        RST_BUTTON_MAP   = 24'hFAC688;
    localparam logic               RST_SCROLL_SWAP  = 1'b0;
    localparam logic [7:0]         RST_ACCELERATION = 8'd0;
    localparam logic signed [15:0] RST_CLIP_MIN_X   = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_MIN_Y   = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_MAX_X   = 16'sd1023;
    localparam logic signed [15:0] RST_CLIP_MAX_Y   = 16'sd767;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture input payload
        logic accel;    // register accelerated deltas
        logic update;   // add, clamp, store state, push on button change
        logic rmem;     // read ring head, capture hit flag
        logic rout;     // load output register, advance read side
    } ptq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free; // output register empty or draining this cycle
    } ptq_sts_t;

endpackage

`default_nettype wire

// File: design/ptq_ctrl.sv
// Sequencing state machine for the pointer tracker event queue.
// Depends on ptq_pkg for command and status types.
`default_nettype none

module ptq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             op,
    input  wire ptq_pkg::ptq_sts_t sts,
    output ptq_pkg::ptq_cmd_t     cmd
);
    import ptq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MACC = 5'b00010,
        S_MUPD = 5'b00100,
        S_RMEM = 5'b01000,
        S_ROUT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_READ) ? S_RMEM : S_MACC;
                end
            end
            S_MACC:
            begin
                cmd.accel  = 1'b1;
                state_next = S_MUPD;
            end
            S_MUPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            S_RMEM:
            begin
                cmd.rmem   = 1'b1;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.rout   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/ptq_dp.sv
// Datapath: configuration registers, pointer state, event ring and output register.
// Depends on ptq_pkg; driven by commands from ptq_ctrl.
`default_nettype none

module ptq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ptq_pkg::ptq_cmd_t               cmd,
    output ptq_pkg::ptq_sts_t                    sts,
    input  wire logic                            cfg_we,
    input  wire logic [ptq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ptq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic signed [10:0]              delta_x,
    input  wire logic signed [10:0]              delta_y,
    input  wire logic [6:0]                      raw_buttons,
    input  wire logic [6:0]                      kbd_buttons,
    input  wire logic [31:0]                     time_ms,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic signed [15:0]                   pos_x,
    output logic signed [15:0]                   pos_y,
    output logic [4:0]                           mapped_buttons,
    output logic [31:0]                          event_time,
    output logic                                 changed
);
    import ptq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [4:0] SCROLL_UP   = 5'd8;
    localparam logic [4:0] SCROLL_DOWN = 5'd16;

    typedef struct packed {
        logic [31:0]        cnt;
        logic [31:0]        tm;
        logic [6:0]         btn;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } entry_t;

    // Accelerate one delta; magnitudes above five go through the multiplier.
    function automatic logic signed [19:0] accel_delta(
        input logic signed [10:0] d,
        input logic [7:0]         lvl
    );
        logic [10:0] mag;
        logic [7:0]  maxacc;
        logic [18:0] res;
        logic signed [19:0] sres;
        mag    = d[10] ? 11'(-d) : 11'(d);
        maxacc = (lvl < 8'd3) ? 8'd2 : lvl;
        if (mag == 11'd4)
        begin
            res = 19'd6 + 19'(lvl >> 2);
        end
        else if (mag == 11'd5)
        begin
            res = 19'd9 + 19'(lvl >> 1);
        end
        else if (mag > 11'd5)
        begin
            res = 19'(mag) * 19'(maxacc);
        end
        else
        begin
            res = 19'(mag);
        end
        sres = $signed({1'b0, res});
        if (lvl == 8'd0)
        begin
            accel_delta = 20'(d);
        end
        else
        begin
            accel_delta = d[10] ? -sres : sres;
        end
    endfunction

    // Clamp to [lo, hi]; the upper bound wins on an empty range.
    function automatic logic signed [15:0] clamp_pos(
        input logic signed [20:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [20:0] t;
        logic signed [20:0] lo_w;
        logic signed [20:0] hi_w;
        lo_w = $signed({{5{lo[15]}}, lo});
        hi_w = $signed({{5{hi[15]}}, hi});
        t = v;
        if (t < lo_w)
        begin
            t = lo_w;
        end
        if (t >= hi_w)
        begin
            t = hi_w;
        end
        clamp_pos = t[15:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers
    logic [23:0]        button_map_reg;
    logic               scroll_swap_reg;
    logic [7:0]         accel_reg;
    logic signed [15:0] clip_min_x_reg;
    logic signed [15:0] clip_min_y_reg;
    logic signed [15:0] clip_max_x_reg;
    logic signed [15:0] clip_max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_map_reg  <= RST_BUTTON_MAP;
            scroll_swap_reg <= RST_SCROLL_SWAP;
            accel_reg       <= RST_ACCELERATION;
            clip_min_x_reg  <= RST_CLIP_MIN_X;
            clip_min_y_reg  <= RST_CLIP_MIN_Y;
            clip_max_x_reg  <= RST_CLIP_MAX_X;
            clip_max_y_reg  <= RST_CLIP_MAX_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BUTTON_MAP:   button_map_reg  <= cfg_data;
                CFG_SCROLL_SWAP:  scroll_swap_reg <= cfg_data[0];
                CFG_ACCELERATION: accel_reg       <= cfg_data[7:0];
                CFG_CLIP_MIN_X:   clip_min_x_reg  <= cfg_data[15:0];
                CFG_CLIP_MIN_Y:   clip_min_y_reg  <= cfg_data[15:0];
                CFG_CLIP_MAX_X:   clip_max_x_reg  <= cfg_data[15:0];
                CFG_CLIP_MAX_Y:   clip_max_y_reg  <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Captured input payload and accelerated deltas
    logic signed [10:0] dx_reg;
    logic signed [10:0] dy_reg;
    logic [6:0]         raw_reg;
    logic [6:0]         kbd_reg;
    logic [31:0]        time_reg;
    logic signed [19:0] ax_reg;
    logic signed [19:0] ay_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= delta_x;
            dy_reg   <= delta_y;
            raw_reg  <= raw_buttons;
            kbd_reg  <= kbd_buttons;
            time_reg <= time_ms;
        end
        if (cmd.accel)
        begin
            ax_reg <= accel_delta(dx_reg, accel_reg);
            ay_reg <= accel_delta(dy_reg, accel_reg);
        end
    end

    // Pointer state and ring control
    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;
    logic [6:0]         cur_btn_reg;
    logic [31:0]        cur_time_reg;
    logic [31:0]        event_cnt_reg;
    logic [31:0]        last_cnt_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic               full_reg;

    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [31:0]        cnt_inc;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic               push;
    entry_t             push_entry;

    always_comb
    begin
        new_x = clamp_pos($signed({{5{cur_x_reg[15]}}, cur_x_reg}) + $signed({ax_reg[19], ax_reg}),
                          clip_min_x_reg, clip_max_x_reg);
        new_y = clamp_pos($signed({{5{cur_y_reg[15]}}, cur_y_reg}) + $signed({ay_reg[19], ay_reg}),
                          clip_min_y_reg, clip_max_y_reg);
        cnt_inc    = event_cnt_reg + 32'd1;
        wr_ptr_inc = ptr_inc(wr_ptr_reg);
        push       = cmd.update && !full_reg && (cur_btn_reg != raw_reg);
        push_entry.cnt = cnt_inc;
        push_entry.tm  = time_reg;
        push_entry.btn = raw_reg | kbd_reg;
        push_entry.y   = new_y;
        push_entry.x   = new_x;
    end

    // Ring storage, written and read in clocked blocks
    entry_t ring_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[wr_ptr_reg] <= push_entry;
        end
        if (cmd.rmem)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Read source selection and button remap
    entry_t      src;
    logic [4:0]  mapped;
    logic [2:0]  low_idx;

    always_comb
    begin
        if (rd_hit_reg)
        begin
            src = rd_data_reg;
        end
        else
        begin
            src.cnt = event_cnt_reg;
            src.tm  = cur_time_reg;
            src.btn = cur_btn_reg;
            src.y   = cur_y_reg;
            src.x   = cur_x_reg;
        end
        low_idx = src.btn[2:0];
        mapped  = {src.btn[4:3], button_map_reg[3*low_idx +: 3]};
        if (scroll_swap_reg)
        begin
            case (mapped)
                SCROLL_UP:   mapped = SCROLL_DOWN;
                SCROLL_DOWN: mapped = SCROLL_UP;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_btn_reg   <= '0;
            cur_time_reg  <= '0;
            event_cnt_reg <= '0;
            last_cnt_reg  <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            full_reg      <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                cur_x_reg     <= new_x;
                cur_y_reg     <= new_y;
                cur_btn_reg   <= raw_reg | kbd_reg;
                cur_time_reg  <= time_reg;
                event_cnt_reg <= cnt_inc;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_inc;
                full_reg   <= (wr_ptr_inc == rd_ptr_reg);
            end
            if (cmd.rmem)
            begin
                rd_hit_reg <= (rd_ptr_reg != wr_ptr_reg);
            end
            if (cmd.rout)
            begin
                full_reg     <= 1'b0;
                last_cnt_reg <= src.cnt;
                if (rd_hit_reg)
                begin
                    rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                end
            end
        end
    end

    // Output register
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.rout)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rout)
        begin
            pos_x          <= src.x;
            pos_y          <= src.y;
            mapped_buttons <= mapped;
            event_time     <= src.tm;
            changed        <= (last_cnt_reg != event_cnt_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// File: design/pointer_tracker_event_queue.sv
// Motion item: accepted, deltas accelerated in S_MACC, position stored in S_MUPD; the next
// item is taken once the controller is back in idle. Read item: ring read in S_RMEM after
// acceptance, result loaded in S_ROUT, later if the output register is still occupied.
// One item is handled at a time, set by the controller sequence: no new item is taken
// before the last one is done. Reset (rst_n low, asynchronous) restores config defaults,
// zeroes state and pointers; ring is not cleared.
`default_nettype none

module pointer_tracker_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input item channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            op,
    input  wire logic signed [10:0]              delta_x,
    input  wire logic signed [10:0]              delta_y,
    input  wire logic [6:0]                      raw_buttons,
    input  wire logic [6:0]                      kbd_buttons,
    input  wire logic [31:0]                     time_ms,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [15:0]                   pos_x,
    output logic signed [15:0]                   pos_y,
    output logic [4:0]                           mapped_buttons,
    output logic [31:0]                          event_time,
    output logic                                 changed,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ptq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ptq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ptq_pkg::*;

    ptq_cmd_t cmd;
    ptq_sts_t sts;

    // Configuration writes are always accepted; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    // Controller: one item at a time. A motion transfer walks accelerate then update;
    // a read transfer walks ring read then output load, holding there while the
    // previous result is still waiting to be taken.
    ptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: clip-rectangle arithmetic, event ring, button remap and the
    // output register that decouples the result side from the input side.
    ptq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .delta_x        (delta_x),
        .delta_y        (delta_y),
        .raw_buttons    (raw_buttons),
        .kbd_buttons    (kbd_buttons),
        .time_ms        (time_ms),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .mapped_buttons (mapped_buttons),
        .event_time     (event_time),
        .changed        (changed)
    );

endmodule

`default_nettype wire

// File: design/ptq_checker.sv
// Port-level checks for pointer_tracker_event_queue, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module ptq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              op,
    input wire logic              out_valid,
    input wire logic              out_ready
);

    // A pending result must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // One item at a time: no input taken right after a transfer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // A motion item taken with the output empty raises no result while it is handled.
    a_motion_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !op && !out_valid |=> !out_valid ##1 !out_valid)
        else $error("result after motion item");

    // A read taken with the output empty raises out_valid once the ring read and output load are done, not earlier.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op && !out_valid |=> !out_valid ##1 !out_valid ##1 out_valid)
        else $error("read result missing or early");

endmodule

bind pointer_tracker_event_queue ptq_checker u_ptq_checker (.*);

`default_nettype wire
